// ===== src/circular_double_ended_queue_defines.svh =====
// ---------------------------------------------------------------------------
// Circular deque assertion macros
// Shared helpers for concurrent checks clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef CIRCULAR_DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define CIRCULAR_DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Same-cycle implication check
`define CDQ_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deque check failed");

// Next-cycle implication check
`define CDQ_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deque check failed");

`endif

// ===== src/cdq_pkg.sv =====
// ---------------------------------------------------------------------------
// Circular deque package
// Sizes, operation and status codes, transaction types and index helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

	localparam int DEPTH = 8;
	localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int DW    = 32;

	typedef logic [IW-1:0] idx_t;

	// Operation codes
	localparam logic [2:0] FN_PUSH_FRONT = 3'd0;
	localparam logic [2:0] FN_PUSH_REAR  = 3'd1;
	localparam logic [2:0] FN_POP_FRONT  = 3'd2;
	localparam logic [2:0] FN_POP_REAR   = 3'd3;
	localparam logic [2:0] FN_PEEK_FRONT = 3'd4;
	localparam logic [2:0] FN_PEEK_REAR  = 3'd5;

	// Status codes
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [2:0]           func;
		logic signed [DW-1:0] push_value;
	} cdq_req_t;

	typedef struct packed {
		logic signed [DW-1:0] read_value;
		logic [1:0]           status;
		logic                 now_empty;
		logic                 now_full;
	} cdq_rsp_t;

	// Advance an index with wrap at the top
	function automatic idx_t idx_next(input idx_t i);
		idx_t r;
		if (i == IW'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = i + 1'b1;
		end
		return r;
	endfunction

	// Step an index back with wrap at the bottom
	function automatic idx_t idx_prev(input idx_t i);
		idx_t r;
		if (i == '0) begin
			r = IW'(DEPTH - 1);
		end else begin
			r = i - 1'b1;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== src/cdq_slot_ram.sv =====
// ---------------------------------------------------------------------------
// Deque slot RAM
// Single-port synchronous RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module cdq_slot_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic             re,
	input  wire logic [AW-1:0]    addr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write the addressed word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
	end

	// Register the addressed word on a read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

// ===== src/circular_double_ended_queue.sv =====
// ---------------------------------------------------------------------------
// Circular double-ended queue
// Push and pop at both ends of a circular word store, with peek at either end.
// ---------------------------------------------------------------------------
// One operation is taken per clock cycle: busy stays low, and the result of
// each transaction appears on rsp with done high for exactly one cycle, in the
// cycle after it was accepted. The receiver cannot stall, so it must take
// every result in that cycle. The result timing follows from the single-port slot RAM:
// every operation makes at most one access to it, a write for a push or a
// read for a pop or peek, and the read data comes back registered, just in time
// for the result. Head, tail and the empty flag live in flops and are updated
// at accept, so the next transaction sees them at once.
// Slots need no clearing after reset; only occupied slots are ever read.
// ---------------------------------------------------------------------------
`default_nettype none
`include "circular_double_ended_queue_defines.svh"

module circular_double_ended_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire cdq_pkg::cdq_req_t req,
	output logic                  done,
	output cdq_pkg::cdq_rsp_t     rsp
);

	import cdq_pkg::*;

	logic accept;
	idx_t head_q, tail_q;
	logic empty_q;
	idx_t head_n, tail_n;
	logic empty_n;
	logic full_cur, full_n;
	logic ram_we, ram_re;
	idx_t ram_addr;
	logic [DW-1:0] ram_rdata;
	logic [1:0] status_n;

	logic       done_s1;
	logic       rd_sel_s1;
	logic [1:0] status_s1;
	logic       now_empty_s1;
	logic       now_full_s1;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Decode the operation against the current indices
	always_comb begin
		full_cur = !empty_q && (idx_next(tail_q) == head_q);
		head_n   = head_q;
		tail_n   = tail_q;
		empty_n  = empty_q;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		ram_addr = head_q;
		status_n = ST_DONE;
		case (req.func)
			FN_PUSH_FRONT, FN_PUSH_REAR: begin
				if (full_cur) begin
					status_n = ST_FULL;
				end else begin
					ram_we = 1'b1;
					if (empty_q) begin
						head_n   = '0;
						tail_n   = '0;
						empty_n  = 1'b0;
						ram_addr = '0;
					end else if (req.func == FN_PUSH_FRONT) begin
						head_n   = idx_prev(head_q);
						ram_addr = head_n;
					end else begin
						tail_n   = idx_next(tail_q);
						ram_addr = tail_n;
					end
				end
			end
			FN_POP_FRONT, FN_POP_REAR, FN_PEEK_FRONT, FN_PEEK_REAR: begin
				if (empty_q) begin
					status_n = ST_EMPTY;
				end else begin
					ram_re = 1'b1;
					if (req.func == FN_POP_FRONT || req.func == FN_PEEK_FRONT) begin
						ram_addr = head_q;
					end else begin
						ram_addr = tail_q;
					end
					if (req.func == FN_POP_FRONT || req.func == FN_POP_REAR) begin
						if (head_q == tail_q) begin
							head_n  = '0;
							tail_n  = '0;
							empty_n = 1'b1;
						end else if (req.func == FN_POP_FRONT) begin
							head_n = idx_next(head_q);
						end else begin
							tail_n = idx_prev(tail_q);
						end
					end
				end
			end
			default: begin
				status_n = ST_DONE;
			end
		endcase
		full_n = !empty_n && (idx_next(tail_n) == head_n);
	end

	// Advance indices on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			empty_q <= 1'b1;
		end else if (accept) begin
			head_q  <= head_n;
			tail_q  <= tail_n;
			empty_q <= empty_n;
		end
	end

	cdq_slot_ram #(
		.WIDTH(DW),
		.DEPTH(DEPTH),
		.AW   (IW)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we && accept),
		.re   (ram_re && accept),
		.addr (ram_addr),
		.wdata(req.push_value),
		.rdata(ram_rdata)
	);

	// Hold the result strobe for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= accept;
		end
	end

	// Capture result fields that do not come from the RAM
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_sel_s1    <= ram_re;
			status_s1    <= status_n;
			now_empty_s1 <= empty_n;
			now_full_s1  <= full_n;
		end
	end

	assign done           = done_s1;
	assign rsp.read_value = rd_sel_s1 ? ram_rdata : '0;
	assign rsp.status     = status_s1;
	assign rsp.now_empty  = now_empty_s1;
	assign rsp.now_full   = now_full_s1;

	// Checks
	`CDQ_ASSERT_NXT(a_done_follows_accept, accept, done)
	`CDQ_ASSERT_NXT(a_no_done_without_accept, !accept, !done)
	`CDQ_ASSERT_IMP(a_empty_indices_home, empty_q, head_q == '0 && tail_q == '0)
	`CDQ_ASSERT_IMP(a_not_empty_and_full, done, !(rsp.now_empty && rsp.now_full))

endmodule

`default_nettype wire

// ===== tb/circular_double_ended_queue_tb.sv =====
// ---------------------------------------------------------------------------
// Circular deque testbench
// Runs directed and random push, pop and peek transactions at both ends.
// A shadow deque predicts each result, and every strobed result is checked
// field by field, in order. The random part moves through push-heavy and
// pop-heavy runs so that the full and empty edges are hit over and over.
// ---------------------------------------------------------------------------
`default_nettype none

module circular_double_ended_queue_tb;

	import cdq_pkg::*;

	// Codes with no operation behind them
	localparam logic [2:0] FN_SPARE_A = 3'd6;
	localparam logic [2:0] FN_SPARE_B = 3'd7;

	localparam int RUN_ITEMS   = 515;
	localparam int CYCLE_LIMIT = 200000;

	logic     clk    = 1'b0;
	logic     arst_n = 1'b0;
	logic     start  = 1'b0;
	cdq_req_t req    = '0;
	logic     busy;
	logic     done;
	cdq_rsp_t rsp;

	int sender_idle_pct = 0;
	int cycle_count     = 0;

	// Shadow deque and the results it still waits for
	class deque_scoreboard;
		logic signed [DW-1:0] slots [DEPTH];
		int                   head;
		int                   tail;
		bit                   empty;
		cdq_rsp_t             awaited_rsp [$];
		int                   errors;

		function new();
			head   = 0;
			tail   = 0;
			empty  = 1'b1;
			errors = 0;
		endfunction

		function bit is_full();
			return !empty && ((tail + 1) % DEPTH == head);
		endfunction

		// Apply one accepted transaction to the shadow and queue its result
		function void note_op(cdq_req_t r);
			cdq_rsp_t e;
			e = '0;
			e.status = ST_DONE;
			case (r.func)
				FN_PUSH_FRONT, FN_PUSH_REAR: begin
					if (is_full()) begin
						e.status = ST_FULL;
					end else begin
						if (empty) begin
							head  = 0;
							tail  = 0;
							empty = 1'b0;
						end else if (r.func == FN_PUSH_FRONT) begin
							head = (head + DEPTH - 1) % DEPTH;
						end else begin
							tail = (tail + 1) % DEPTH;
						end
						slots[(r.func == FN_PUSH_FRONT) ? head : tail] = r.push_value;
					end
				end
				FN_POP_FRONT, FN_POP_REAR, FN_PEEK_FRONT, FN_PEEK_REAR: begin
					if (empty) begin
						e.status = ST_EMPTY;
					end else begin
						if (r.func == FN_POP_FRONT || r.func == FN_PEEK_FRONT) begin
							e.read_value = slots[head];
						end else begin
							e.read_value = slots[tail];
						end
						if (r.func == FN_POP_FRONT || r.func == FN_POP_REAR) begin
							if (head == tail) begin
								empty = 1'b1;
								head  = 0;
								tail  = 0;
							end else if (r.func == FN_POP_FRONT) begin
								head = (head + 1) % DEPTH;
							end else begin
								tail = (tail + DEPTH - 1) % DEPTH;
							end
						end
					end
				end
				default: begin
				end
			endcase
			e.now_empty = empty;
			e.now_full  = is_full();
			awaited_rsp.push_back(e);
		endfunction

		// Compare one strobed result with the oldest expectation
		function void check_rsp(cdq_rsp_t got);
			cdq_rsp_t e;
			if (awaited_rsp.size() == 0) begin
				$display("%0t unexpected result: expected none, got %h", $time, got);
				errors++;
				return;
			end
			e = awaited_rsp.pop_front();
			if (got.read_value !== e.read_value) begin
				$display("%0t read_value: expected %0d, got %0d",
					$time, e.read_value, got.read_value);
				errors++;
			end
			if (got.status !== e.status) begin
				$display("%0t status: expected %0d, got %0d", $time, e.status, got.status);
				errors++;
			end
			if (got.now_empty !== e.now_empty) begin
				$display("%0t now_empty: expected %b, got %b",
					$time, e.now_empty, got.now_empty);
				errors++;
			end
			if (got.now_full !== e.now_full) begin
				$display("%0t now_full: expected %b, got %b",
					$time, e.now_full, got.now_full);
				errors++;
			end
		endfunction
	endclass

	deque_scoreboard sb = new();

	circular_double_ended_queue u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Note accepted transactions, then check strobed results
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				sb.note_op(req);
			end
			if (done) begin
				sb.check_rsp(rsp);
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic [DW-1:0] pick_word();
		logic [DW-1:0] w;
		case ($urandom_range(9))
			0:       w = 32'h8000_0000;
			1:       w = 32'h7FFF_FFFF;
			2:       w = '1;
			3:       w = '0;
			default: w = $urandom();
		endcase
		return w;
	endfunction

	// Present one transaction, hold until accepted, then maybe idle
	task automatic send_op(input logic [2:0] fn, input logic [DW-1:0] value);
		start          <= 1'b1;
		req.func       <= fn;
		req.push_value <= value;
		do @(posedge clk); while (busy !== 1'b0);
		if ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (sb.awaited_rsp.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// One random stretch; push weight moves between runs to sweep fill level
	task automatic random_run(input int count);
		int       push_pct;
		int       run_left;
		logic [2:0] fn;
		push_pct = 50;
		run_left = 0;
		for (int n = 0; n < count; n++) begin
			if (run_left == 0) begin
				case ($urandom_range(2))
					0:       push_pct = 80;
					1:       push_pct = 50;
					default: push_pct = 20;
				endcase
				run_left = $urandom_range(10, 40);
			end
			run_left--;
			if ($urandom_range(99) < 3) begin
				fn = $urandom_range(1) ? FN_SPARE_A : FN_SPARE_B;
			end else if ($urandom_range(99) < push_pct) begin
				fn = $urandom_range(1) ? FN_PUSH_FRONT : FN_PUSH_REAR;
			end else if ($urandom_range(3) == 0) begin
				fn = $urandom_range(1) ? FN_PEEK_FRONT : FN_PEEK_REAR;
			end else begin
				fn = $urandom_range(1) ? FN_POP_FRONT : FN_POP_REAR;
			end
			send_op(fn, pick_word());
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty deque: every read is rejected
		send_op(FN_PEEK_FRONT, 32'h1234_5678);
		send_op(FN_POP_FRONT, 32'h0);
		send_op(FN_POP_REAR, 32'hFFFF_FFFF);
		send_op(FN_PEEK_REAR, 32'h0);
		// Push at both ends, read both ends, drain to empty
		send_op(FN_PUSH_FRONT, 32'h8000_0000);
		send_op(FN_PUSH_REAR, 32'h7FFF_FFFF);
		send_op(FN_PEEK_FRONT, 32'h0);
		send_op(FN_PEEK_REAR, 32'h0);
		send_op(FN_POP_REAR, 32'h0);
		send_op(FN_POP_FRONT, 32'h0);
		send_op(FN_SPARE_A, 32'hFFFF_FFFF);
		send_op(FN_SPARE_B, 32'hFFFF_FFFF);
		// Fill from both ends with wrap, then push into a full deque
		for (int k = 0; k < DEPTH; k++) begin
			send_op((k % 2 == 0) ? FN_PUSH_FRONT : FN_PUSH_REAR, pick_word());
		end
		send_op(FN_PUSH_FRONT, 32'h5555_5555);
		send_op(FN_PUSH_REAR, 32'hAAAA_AAAA);
		send_op(FN_POP_FRONT, 32'h0);
		send_op(FN_POP_REAR, 32'h0);

		// Hold off until every result is back
		drain_results();
		@(posedge clk);

		sender_idle_pct = 12;
		random_run(RUN_ITEMS);
		sender_idle_pct = 65;
		random_run(RUN_ITEMS);
		sender_idle_pct = 0;
		random_run(RUN_ITEMS);

		drain_results();
		repeat (4) @(posedge clk);

		if (sb.awaited_rsp.size() != 0) begin
			$display("%0t missing results: expected %0d more, got none",
				$time, sb.awaited_rsp.size());
			sb.errors++;
		end
		if (sb.errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

`default_nettype wire
